### rtl/core/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg: shared definitions of the BMP pixel unpacker
// Register indexes, reset values, field widths, the queue entry that carries
// one finished pixel from the front end to the channel emitter, and the
// trailing-zero helper used on the channel masks.
// ----------------------------------------------------------------------------
package bpu_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam int MASK_W    = 32;
    localparam int BPP_W     = 3;
    localparam int DIM_REG_W = 13;
    localparam int COORD_W   = 12;
    localparam int NUM_CH    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int TZ_W      = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RED_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [MASK_W-1:0]    RST_RED_MASK   = 32'h00FF_0000;
    localparam logic [MASK_W-1:0]    RST_GREEN_MASK = 32'h0000_FF00;
    localparam logic [MASK_W-1:0]    RST_BLUE_MASK  = 32'h0000_00FF;
    localparam logic [MASK_W-1:0]    RST_ALPHA_MASK = 32'hFF00_0000;
    localparam logic [BPP_W-1:0]     RST_BPP        = 3'd4;
    localparam logic [DIM_REG_W-1:0] RST_WIDTH      = 13'd1;
    localparam logic [DIM_REG_W-1:0] RST_HEIGHT     = 13'd1;

    localparam logic [BPP_W-1:0] BPP_MIN = 3'd1;
    localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

    // Depth of the pixel queue between front end and emitter.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [MASK_W-1:0]  pixel;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last_img;
    } bpu_entry_t;

    // Position of the lowest set bit. The lowest bit is isolated first, so
    // the encode is a plain OR over independent bits. Zero gives zero.
    function automatic logic [TZ_W-1:0] trailing_zeros(input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] low;
        logic [TZ_W-1:0]   idx;
        low = m & (~m + 32'd1);
        idx = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (low[i])
            begin
                idx = idx | TZ_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/core/bpu_front.sv
// ----------------------------------------------------------------------------
// bpu_front: byte gathering and position tracking
// Packs little-endian bytes into pixels, skips row padding, tracks column and
// source row, and pushes each finished pixel with its coordinates.
// ----------------------------------------------------------------------------
module bpu_front #(
    parameter int MAX_DIM = bpu_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [7:0]                     data_byte,
    input  logic                           frame_start,
    input  logic [bpu_pkg::BPP_W-1:0]      bpp,
    input  logic [$clog2(MAX_DIM+1)-1:0]   width,
    input  logic [$clog2(MAX_DIM+1)-1:0]   height,
    input  logic                           bottom_up,
    output logic                           push,
    output bpu_pkg::bpu_entry_t            push_entry
);
    import bpu_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    logic [23:0]      word_reg, word_next, word_b;
    logic [1:0]       bip_reg, bip_next, bip_b;
    logic [CNT_W-1:0] col_reg, col_next, col_b, col_u;
    logic [CNT_W-1:0] row_reg, row_next, row_b, row_u, row_adv;
    logic [1:0]       pad_reg, pad_next, pad_b, pad_dec, pad_val;
    logic             inpad_reg, inpad_next, inpad_b;
    logic [3:0]       row_bytes_lo;
    logic [MASK_W-1:0] pixel;
    logic [DIM_W-1:0] col_inc, row_inc, y_full;
    logic             partial;

    always_comb
    begin
        // A new image starts from cleared counters before the byte is used.
        word_b  = frame_start ? '0 : word_reg;
        bip_b   = frame_start ? '0 : bip_reg;
        col_b   = frame_start ? '0 : col_reg;
        row_b   = frame_start ? '0 : row_reg;
        pad_b   = frame_start ? '0 : pad_reg;
        inpad_b = frame_start ? 1'b0 : inpad_reg;

        // Counters beyond a freshly shrunk image restart at zero.
        col_u = (DIM_W'(col_b) >= width)  ? '0 : col_b;
        row_u = (DIM_W'(row_b) >= height) ? '0 : row_b;

        row_inc = DIM_W'(row_u) + DIM_W'(1);
        row_adv = (row_inc >= height) ? '0 : CNT_W'(row_inc);
        col_inc = DIM_W'(col_u) + DIM_W'(1);

        // Padding brings each row to a multiple of four bytes.
        row_bytes_lo = {2'b00, width[1:0]} * {2'b00, bpp[1:0]};
        pad_val      = 2'(2'd0 - row_bytes_lo[1:0]);
        pad_dec      = (pad_b != 2'd0) ? 2'(pad_b - 2'd1) : 2'd0;

        pixel   = {8'h00, word_b} | (MASK_W'(data_byte) << {bip_b, 3'b000});
        partial = (BPP_W'(bip_b) + BPP_W'(1)) < bpp;

        y_full = bottom_up ? DIM_W'(height - DIM_W'(1) - DIM_W'(row_u)) : DIM_W'(row_u);

        push_entry.pixel    = pixel;
        push_entry.x        = COORD_W'(col_u);
        push_entry.y        = COORD_W'(y_full);
        push_entry.last_img = (DIM_W'(col_u) == DIM_W'(width - DIM_W'(1)))
                           && (DIM_W'(row_u) == DIM_W'(height - DIM_W'(1)));

        word_next  = word_b;
        bip_next   = bip_b;
        col_next   = col_u;
        row_next   = row_u;
        pad_next   = pad_b;
        inpad_next = inpad_b;
        push       = 1'b0;

        if (inpad_b)
        begin
            pad_next = pad_dec;
            if (pad_dec == 2'd0)
            begin
                inpad_next = 1'b0;
                row_next   = row_adv;
            end
        end
        else if (partial)
        begin
            word_next = pixel[23:0];
            bip_next  = 2'(bip_b + 2'd1);
        end
        else
        begin
            push      = accept;
            word_next = '0;
            bip_next  = '0;
            if (col_inc >= width)
            begin
                col_next = '0;
                if (pad_val != 2'd0)
                begin
                    inpad_next = 1'b1;
                    pad_next   = pad_val;
                end
                else
                begin
                    row_next = row_adv;
                end
            end
            else
            begin
                col_next = CNT_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            bip_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            pad_reg   <= '0;
            inpad_reg <= 1'b0;
        end
        else if (accept)
        begin
            word_reg  <= word_next;
            bip_reg   <= bip_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pad_reg   <= pad_next;
            inpad_reg <= inpad_next;
        end
    end

endmodule

### rtl/core/bpu_queue.sv
// ----------------------------------------------------------------------------
// bpu_queue: pixel queue
// A short first-in first-out buffer of finished pixels between the front end
// and the channel emitter.
// ----------------------------------------------------------------------------
module bpu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bpu_pkg::bpu_entry_t push_entry,
    input  logic                pop,
    output bpu_pkg::bpu_entry_t head,
    output logic                empty,
    output logic                full
);
    import bpu_pkg::*;

    bpu_entry_t      slots [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? Q_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? Q_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = (Q_AW+1)'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = (Q_AW+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/bpu_back.sv
// ----------------------------------------------------------------------------
// bpu_back: channel emitter
// Takes one pixel at a time from the queue and emits one masked, shifted channel
// per cycle, while out_stall is low, into the output register, in red, green, blue, alpha order.
// ----------------------------------------------------------------------------
module bpu_back (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic [bpu_pkg::NUM_CH-1:0][bpu_pkg::MASK_W-1:0] masks,
    input  bpu_pkg::bpu_entry_t                            head,
    input  logic                                           q_empty,
    output logic                                           pop,
    output logic                                           out_valid,
    input  logic                                           out_stall,
    output logic [7:0]                                     channel_value,
    output logic [1:0]                                     channel_index,
    output logic [bpu_pkg::COORD_W-1:0]                    pixel_x,
    output logic [bpu_pkg::COORD_W-1:0]                    pixel_y,
    output logic                                           last_of_pixel,
    output logic                                           last_of_image
);
    import bpu_pkg::*;

    bpu_entry_t        cur_reg;
    logic [NUM_CH-1:0] rem_reg, rem_next, nz, sel, rem_after;
    logic              active_reg, active_next;
    logic              can_emit, emit, free;
    logic [1:0]        ch;
    logic [MASK_W-1:0] m;
    logic [TZ_W-1:0]   tz;
    logic [MASK_W-1:0] shifted;

    logic              out_valid_reg;
    logic [7:0]        value_reg;
    logic [1:0]        index_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic              lop_reg, loi_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            nz[i] = (masks[i] != '0);
        end

        can_emit  = !out_valid_reg || !out_stall;
        emit      = active_reg && can_emit;
        sel       = rem_reg & (~rem_reg + NUM_CH'(1));
        rem_after = rem_reg & ~sel;
        free      = !active_reg || (emit && (rem_after == '0));
        pop       = free && !q_empty;

        ch = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (sel[i])
            begin
                ch = ch | 2'(i);
            end
        end

        m       = masks[ch];
        tz      = trailing_zeros(m);
        shifted = (cur_reg.pixel & m) >> tz;

        rem_next    = rem_reg;
        active_next = active_reg;
        if (pop)
        begin
            rem_next    = nz;
            active_next = (nz != '0);
        end
        else if (emit)
        begin
            rem_next    = rem_after;
            active_next = (rem_after != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            rem_reg    <= rem_next;
            if (can_emit)
            begin
                out_valid_reg <= active_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (emit)
        begin
            value_reg <= shifted[7:0];
            index_reg <= ch;
            x_reg     <= cur_reg.x;
            y_reg     <= cur_reg.y;
            lop_reg   <= (rem_after == '0);
            loi_reg   <= (rem_after == '0) && cur_reg.last_img;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_value = value_reg;
    assign channel_index = index_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign last_of_pixel = lop_reg;
    assign last_of_image = loi_reg;

endmodule

### rtl/core/bmp_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker: streaming BMP bitfields pixel decoder
// The input channel takes the raw pixel array, one byte per item, padding
// included; frame_start marks the first byte of an image and clears all
// counters. For every finished pixel the output channel gives one item per
// nonzero mask (red, green, blue, alpha order) with column, destination row
// and last-of-pixel / last-of-image flags.
// Throughput: one byte per cycle while in_stall is low. The emitter delivers
// one channel per cycle while out_stall is low, so a pixel with more nonzero
// masks than stored bytes slows the input once the four-entry pixel queue fills.
// The last byte of a pixel writes it into the queue; the emitter then loads
// it into its current-pixel register and registers each channel for output.
// in_stall rises only while the pixel queue is full; out_stall holds the
// output register, and bytes keep flowing until the queue fills behind it.
// Reset returns the registers to their defaults (32-bit BGRA, 1x1 image,
// bottom-up) and empties the queue and the output register.
// Configuration is to be written only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker #(
    parameter int MAX_DIM = bpu_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpu_pkg::MASK_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           frame_start,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     channel_value,
    output logic [1:0]                     channel_index,
    output logic [bpu_pkg::COORD_W-1:0]    pixel_x,
    output logic [bpu_pkg::COORD_W-1:0]    pixel_y,
    output logic                           last_of_pixel,
    output logic                           last_of_image
);
    import bpu_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;

    // Configuration registers, kept at their architected widths.
    logic [NUM_CH-1:0][MASK_W-1:0] masks_reg;
    logic [BPP_W-1:0]              bpp_reg;
    logic [DIM_REG_W-1:0]          width_reg;
    logic [DIM_REG_W-1:0]          height_reg;
    logic                          bottom_up_reg;

    // Effective settings after range limiting.
    logic [BPP_W-1:0] bpp_eff;
    logic [CMP_W-1:0] width_ext, height_ext;
    logic [DIM_W-1:0] width_eff, height_eff;

    logic       accept;
    logic       push, pop, q_empty, q_full;
    bpu_entry_t push_entry, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg[0]  <= RST_RED_MASK;
            masks_reg[1]  <= RST_GREEN_MASK;
            masks_reg[2]  <= RST_BLUE_MASK;
            masks_reg[3]  <= RST_ALPHA_MASK;
            bpp_reg       <= RST_BPP;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            bottom_up_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RED_MASK:   masks_reg[0]  <= cfg_wdata;
                REG_GREEN_MASK: masks_reg[1]  <= cfg_wdata;
                REG_BLUE_MASK:  masks_reg[2]  <= cfg_wdata;
                REG_ALPHA_MASK: masks_reg[3]  <= cfg_wdata;
                REG_BPP:        bpp_reg       <= cfg_wdata[BPP_W-1:0];
                REG_WIDTH:      width_reg     <= cfg_wdata[DIM_REG_W-1:0];
                REG_HEIGHT:     height_reg    <= cfg_wdata[DIM_REG_W-1:0];
                REG_BOTTOM_UP:  bottom_up_reg <= cfg_wdata[0];
                default:        bottom_up_reg <= bottom_up_reg;
            endcase
        end
    end

    // A zero byte count acts as one byte, anything above four as four.
    // Image sizes of zero act as one, sizes above MAX_DIM as MAX_DIM.
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            bpp_eff = BPP_MIN;
        end
        else if (bpp_reg > BPP_MAX)
        begin
            bpp_eff = BPP_MAX;
        end
        else
        begin
            bpp_eff = bpp_reg;
        end

        width_ext  = CMP_W'(width_reg);
        height_ext = CMP_W'(height_reg);

        if (width_ext == '0)
        begin
            width_eff = DIM_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_DIM))
        begin
            width_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            width_eff = DIM_W'(width_ext);
        end

        if (height_ext == '0)
        begin
            height_eff = DIM_W'(1);
        end
        else if (height_ext > CMP_W'(MAX_DIM))
        begin
            height_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            height_eff = DIM_W'(height_ext);
        end
    end

    // The front end stalls whenever the pixel queue is full, also for bytes that finish no pixel.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    bpu_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .bpp         (bpp_eff),
        .width       (width_eff),
        .height      (height_eff),
        .bottom_up   (bottom_up_reg),
        .push        (push),
        .push_entry  (push_entry)
    );

    bpu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    bpu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .masks         (masks_reg),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_value (channel_value),
        .channel_index (channel_index),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_of_pixel (last_of_pixel),
        .last_of_image (last_of_image)
    );

endmodule
